// ----- hw/rtl/sgm_pkg.sv -----
// Sobel gradient magnitude: shared constants and types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package sgm_pkg;

   localparam int COL_OUT_BITS  = 11;
   localparam int ROW_BITS      = 12;
   localparam int MAG_BITS      = 15;
   localparam int REQ_PIX_BITS  = 12;
   localparam int LW_BITS       = 12;
   localparam int LC_BITS       = 13;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [LW_BITS-1:0] LW_RESET       = 12'd640;
   localparam logic [LC_BITS-1:0] LC_RESET       = 13'd480;
   localparam logic [LC_BITS-1:0] LINE_COUNT_MIN = 13'd3;
   localparam logic [LC_BITS-1:0] LINE_COUNT_MAX = 13'd4096;
   localparam int                 LINE_WIDTH_MIN = 3;

   localparam logic REG_LINE_WIDTH = 1'b0;
   localparam logic REG_LINE_COUNT = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int QLVL_BITS   = 3;

   typedef struct packed {
      logic [COL_OUT_BITS-1:0] col;
      logic [ROW_BITS-1:0]     row;
      logic                    last;
   } tag_type;

   typedef struct packed {
      logic [LW_BITS-1:0] line_width;
      logic [LC_BITS-1:0] line_count;
   } cfg_type;

endpackage

// ----- hw/rtl/sgm_front.sv -----
// Sobel front end: pixel intake, position counters, line stores, 3x3 window, Sobel sums.
// Depends on sgm_pkg; feeds sgm_queue.
`timescale 1ns / 1ps

module sgm_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sgm_pkg::cfg_type                      cfg,
   input  logic                                  push,
   output logic                                  full,
   input  logic [sgm_pkg::REQ_PIX_BITS-1:0]      req_pixel,
   input  logic                                  req_frame_start,
   input  logic [sgm_pkg::QLVL_BITS-1:0]         q_level,
   output logic                                  q_push,
   output logic [2*(PIXEL_BITS+3)+$bits(sgm_pkg::tag_type)-1:0] q_data
);

   localparam int PB   = PIXEL_BITS;
   localparam int GW   = PIXEL_BITS + 3;
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = ($clog2(MAX_WIDTH + 1) > sgm_pkg::LW_BITS) ?
                         $clog2(MAX_WIDTH + 1) : sgm_pkg::LW_BITS;
   localparam int RW   = sgm_pkg::ROW_BITS;
   localparam int HW   = sgm_pkg::LC_BITS;
   localparam int COB  = sgm_pkg::COL_OUT_BITS;
   localparam int LVW  = sgm_pkg::QLVL_BITS + 1;

   logic [PB-1:0] store_a [MAX_WIDTH];
   logic [PB-1:0] store_b [MAX_WIDTH];

   logic [CW-1:0]        col_ff, col_in, col_cur;
   logic [RW-1:0]        row_ff, row_in, row_cur;
   logic                 s1_valid_ff;
   logic                 s1_emit_ff, s1_emit_in;
   logic [PB-1:0]        s1_px_ff, px;
   logic [CW-1:0]        s1_col_ff;
   sgm_pkg::tag_type     s1_tag_ff, s1_tag_in;
   logic [PB-1:0]        a_rd_ff, b_rd_ff;
   logic [PB-1:0]        mid_ff [3];
   logic [PB-1:0]        right_ff [3];
   logic [CMPW-1:0]      lw_ext, w_eff;
   logic [HW-1:0]        h_eff;
   logic                 accept, col_wrap, row_wrap, fwd;
   logic [GW-1:0]        rsum, lsum, tsum, bsum;
   logic signed [GW-1:0] gx, gy;

   assign px     = PB'(req_pixel);
   assign accept = push && !full;
   assign full   = (LVW'(q_level) + LVW'(s1_valid_ff)) >= LVW'(sgm_pkg::QUEUE_DEPTH);

   assign lw_ext = CMPW'(cfg.line_width);
   always_comb begin
      priority if (lw_ext < CMPW'(sgm_pkg::LINE_WIDTH_MIN)) begin
         w_eff = CMPW'(sgm_pkg::LINE_WIDTH_MIN);
      end else if (lw_ext > CMPW'(MAX_WIDTH)) begin
         w_eff = CMPW'(MAX_WIDTH);
      end else begin
         w_eff = lw_ext;
      end
      priority if (cfg.line_count < sgm_pkg::LINE_COUNT_MIN) begin
         h_eff = sgm_pkg::LINE_COUNT_MIN;
      end else if (cfg.line_count > sgm_pkg::LINE_COUNT_MAX) begin
         h_eff = sgm_pkg::LINE_COUNT_MAX;
      end else begin
         h_eff = cfg.line_count;
      end
   end

   always_comb begin
      col_cur  = req_frame_start ? '0 : col_ff;
      row_cur  = req_frame_start ? '0 : row_ff;
      col_wrap = (CMPW'(col_cur) + CMPW'(1)) >= w_eff;
      row_wrap = (HW'(row_cur) + HW'(1)) >= h_eff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         col_in = col_wrap ? '0 : col_cur + CW'(1);
         row_in = !col_wrap ? row_cur : (row_wrap ? '0 : row_cur + RW'(1));
      end
      s1_emit_in     = (col_cur >= CW'(2)) && (row_cur >= RW'(2));
      s1_tag_in.col  = COB'(col_cur - CW'(2));
      s1_tag_in.row  = row_cur - RW'(2);
      s1_tag_in.last = col_wrap && row_wrap;
      fwd            = s1_valid_ff && (s1_col_ff == col_cur);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff   <= px;
         s1_col_ff  <= col_cur;
         s1_emit_ff <= s1_emit_in;
         s1_tag_ff  <= s1_tag_in;
      end
   end

   // line stores: read at intake, written in the cycle after
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         store_a[s1_col_ff] <= s1_px_ff;
         store_b[s1_col_ff] <= a_rd_ff;
      end
      if (accept) begin
         if (fwd) begin
            a_rd_ff <= s1_px_ff;
            b_rd_ff <= a_rd_ff;
         end else begin
            a_rd_ff <= store_a[col_cur];
            b_rd_ff <= store_b[col_cur];
         end
      end
   end

   // window after shift: left = mid_ff, middle = right_ff, right = {b_rd, a_rd, px}
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         mid_ff[0]   <= right_ff[0];
         mid_ff[1]   <= right_ff[1];
         mid_ff[2]   <= right_ff[2];
         right_ff[0] <= b_rd_ff;
         right_ff[1] <= a_rd_ff;
         right_ff[2] <= s1_px_ff;
      end
   end

   always_comb begin
      rsum = GW'(b_rd_ff) + (GW'(a_rd_ff) << 1) + GW'(s1_px_ff);
      lsum = GW'(mid_ff[0]) + (GW'(mid_ff[1]) << 1) + GW'(mid_ff[2]);
      tsum = GW'(mid_ff[0]) + (GW'(right_ff[0]) << 1) + GW'(b_rd_ff);
      bsum = GW'(mid_ff[2]) + (GW'(right_ff[2]) << 1) + GW'(s1_px_ff);
      gx   = signed'(rsum - lsum);
      gy   = signed'(tsum - bsum);
   end

   assign q_push = s1_valid_ff && s1_emit_ff;
   assign q_data = {gx, gy, s1_tag_ff};

endmodule

// ----- hw/rtl/sgm_queue.sv -----
// Small register queue between the Sobel front end and the magnitude back end.
// Depends on sgm_pkg for depth and pointer widths.
`timescale 1ns / 1ps

module sgm_queue #(
   parameter int ITEM_BITS = 33
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [ITEM_BITS-1:0]          push_data,
   input  logic                          pop,
   output logic [ITEM_BITS-1:0]          pop_data,
   output logic                          empty,
   output logic [sgm_pkg::QLVL_BITS-1:0] level
);

   localparam int PW = sgm_pkg::QPTR_BITS;
   localparam int LW = sgm_pkg::QLVL_BITS;

   logic [ITEM_BITS-1:0] slot_ff [sgm_pkg::QUEUE_DEPTH];
   logic [PW-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [LW-1:0]        count_ff, count_in;
   logic                 do_pop;

   assign empty    = (count_ff == '0);
   assign level    = count_ff;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff + LW'(push) - LW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/sgm_back.sv -----
// Sobel back end: squares the gradients and finds the integer square root,
// one root bit per cycle, into an output register. Depends on sgm_pkg.
`timescale 1ns / 1ps

module sgm_back #(
   parameter int PIXEL_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_empty,
   output logic                                  q_pop,
   input  logic [2*(PIXEL_BITS+3)+$bits(sgm_pkg::tag_type)-1:0] q_data,
   input  logic                                  pop,
   output logic                                  empty,
   output logic [sgm_pkg::MAG_BITS-1:0]          rsp_magnitude,
   output logic [sgm_pkg::COL_OUT_BITS-1:0]      rsp_out_col,
   output logic [sgm_pkg::ROW_BITS-1:0]          rsp_out_row,
   output logic                                  rsp_last_of_frame
);

   localparam int GW  = PIXEL_BITS + 3;
   localparam int SQW = 2 * GW - 1;
   localparam int TB  = $bits(sgm_pkg::tag_type);
   localparam int MB  = sgm_pkg::MAG_BITS;
   localparam logic [SQW-1:0] BIT_INIT = SQW'(1) << (2 * (GW - 1));

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SQUARE = 5'b00010,
      ST_SUM    = 5'b00100,
      ST_ROOT   = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic signed [GW-1:0]    gx_ff, gy_ff;
   sgm_pkg::tag_type        tag_ff, out_tag_ff;
   logic signed [2*GW-1:0]  prod_x, prod_y;
   logic [SQW-1:0]          sqx_ff, sqy_ff;
   logic [SQW-1:0]          rad_ff, rad_in, root_ff, root_in, bit_ff, trial;
   logic [MB-1:0]           out_mag_ff;
   logic                    out_valid_ff, out_valid_in, out_load, ge;

   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;
   assign out_load = (state_ff == ST_DONE) && (!out_valid_ff || pop);

   always_comb begin
      prod_x  = gx_ff * gx_ff;
      prod_y  = gy_ff * gy_ff;
      trial   = root_ff + bit_ff;
      ge      = rad_ff >= trial;
      rad_in  = ge ? rad_ff - trial : rad_ff;
      root_in = ge ? (root_ff >> 1) + bit_ff : root_ff >> 1;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_ROOT;
         ST_ROOT: begin
            if (bit_ff == SQW'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
      out_valid_in = out_load || (out_valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         gx_ff  <= signed'(q_data[2*GW+TB-1 -: GW]);
         gy_ff  <= signed'(q_data[GW+TB-1 -: GW]);
         tag_ff <= q_data[TB-1:0];
      end
      if (state_ff == ST_SQUARE) begin
         sqx_ff <= prod_x[SQW-1:0];
         sqy_ff <= prod_y[SQW-1:0];
      end
      if (state_ff == ST_SUM) begin
         rad_ff  <= sqx_ff + sqy_ff;
         root_ff <= '0;
         bit_ff  <= BIT_INIT;
      end
      if (state_ff == ST_ROOT) begin
         rad_ff  <= rad_in;
         root_ff <= root_in;
         bit_ff  <= bit_ff >> 2;
      end
      if (out_load) begin
         out_mag_ff <= root_ff[MB-1:0];
         out_tag_ff <= tag_ff;
      end
   end

   assign empty             = !out_valid_ff;
   assign rsp_magnitude     = out_mag_ff;
   assign rsp_out_col       = out_tag_ff.col;
   assign rsp_out_row       = out_tag_ff.row;
   assign rsp_last_of_frame = out_tag_ff.last;

endmodule

// ----- hw/rtl/sobel_gradient_magnitude_top.sv -----
// Sobel gradient magnitude top level: configuration registers and the
// front end, queue and back end. Depends on sgm_pkg, sgm_front, sgm_queue, sgm_back.
`timescale 1ns / 1ps

// Takes raster-order pixels one per clock and returns, for every 3x3 window that
// fits inside the frame, floor(sqrt(gx^2 + gy^2)) tagged with the window's top-left
// column and row, the frame's bottom-right window flagged as last. The front end
// takes one pixel per clock while the four-entry queue to the back end has room.
// Each result then passes the back end's square, sum, root and done states; its square
// root unit resolves one root bit per cycle, and the back end takes no new result until
// the last is loaded into its output register. That unit sets the sustained rate for
// interior pixels; border pixels make no result. The line stores need no clearing
// after reset. Registers: line_width at 0x0, line_count at 0x4.

module sobel_gradient_magnitude_top #(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [sgm_pkg::REQ_PIX_BITS-1:0]    req_pixel,
   input  logic                                req_frame_start,
   output logic                                empty,
   input  logic                                pop,
   output logic [sgm_pkg::MAG_BITS-1:0]        rsp_magnitude,
   output logic [sgm_pkg::COL_OUT_BITS-1:0]    rsp_out_col,
   output logic [sgm_pkg::ROW_BITS-1:0]        rsp_out_row,
   output logic                                rsp_last_of_frame,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sgm_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [sgm_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [sgm_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);

   localparam int ITEM_BITS = 2 * (PIXEL_BITS + 3) + $bits(sgm_pkg::tag_type);
   localparam int DW        = sgm_pkg::CSR_DATA_BITS;

   sgm_pkg::cfg_type                cfg_ff;
   logic                            csr_write;
   logic                            q_push, q_pop, q_empty;
   logic [ITEM_BITS-1:0]            q_wdata, q_rdata;
   logic [sgm_pkg::QLVL_BITS-1:0]   q_level;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width <= sgm_pkg::LW_RESET;
         cfg_ff.line_count <= sgm_pkg::LC_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            sgm_pkg::REG_LINE_WIDTH: cfg_ff.line_width <= pwdata[sgm_pkg::LW_BITS-1:0];
            sgm_pkg::REG_LINE_COUNT: cfg_ff.line_count <= pwdata[sgm_pkg::LC_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         sgm_pkg::REG_LINE_WIDTH: prdata = DW'(cfg_ff.line_width);
         sgm_pkg::REG_LINE_COUNT: prdata = DW'(cfg_ff.line_count);
         default:                 prdata = '0;
      endcase
   end

   sgm_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .push            (push),
      .full            (full),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .q_level         (q_level),
      .q_push          (q_push),
      .q_data          (q_wdata)
   );

   sgm_queue #(
      .ITEM_BITS (ITEM_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty),
      .level     (q_level)
   );

   sgm_back #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .q_data            (q_rdata),
      .pop               (pop),
      .empty             (empty),
      .rsp_magnitude     (rsp_magnitude),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

// ----- tb/tb_top.sv -----
// Testbench for sobel_gradient_magnitude_top: streams raster pixel frames, writes
// and reads back the size registers, predicts every gradient and checks each item.
// Depends on sgm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;

   localparam int     MAX_WIDTH    = 2048;
   localparam int     MAX_LINES    = 4096;
   localparam int     PIX_MAX      = 4095;
   localparam int     SETTLE       = 40;
   localparam int     LONG_HOLD    = 400;
   localparam int     MAX_REPORTS  = 10;
   localparam int     RANDOM_ITEMS = 1450;
   localparam int     WIDE_ITEMS   = 200;
   localparam int     TALL_ROWS    = 40;
   localparam longint LIMIT        = 5_000_000;

   localparam logic [sgm_pkg::REQ_PIX_BITS-1:0] PIX_ONES = '1;

   typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_SMOOTH, PIX_RAMP} pix_style_type;

   typedef struct {
      logic [sgm_pkg::MAG_BITS-1:0]     magnitude;
      logic [sgm_pkg::COL_OUT_BITS-1:0] col;
      logic [sgm_pkg::ROW_BITS-1:0]     row;
      logic                             last;
   } gradient_type;

   logic                              clock;
   logic                              reset;
   logic                              push;
   logic                              full;
   logic [sgm_pkg::REQ_PIX_BITS-1:0]  req_pixel;
   logic                              req_frame_start;
   logic                              empty;
   logic                              pop;
   logic [sgm_pkg::MAG_BITS-1:0]      rsp_magnitude;
   logic [sgm_pkg::COL_OUT_BITS-1:0]  rsp_out_col;
   logic [sgm_pkg::ROW_BITS-1:0]      rsp_out_row;
   logic                              rsp_last_of_frame;
   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [sgm_pkg::CSR_ADDR_BITS-1:0] paddr;
   logic [sgm_pkg::CSR_DATA_BITS-1:0] pwdata;
   logic [sgm_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                              pready;

   // predictor state
   logic [sgm_pkg::REQ_PIX_BITS-1:0] prev_row_px  [MAX_WIDTH];
   logic [sgm_pkg::REQ_PIX_BITS-1:0] prev2_row_px [MAX_WIDTH];
   int                               win [3][3];
   int unsigned                      pix_col;
   int unsigned                      pix_row;
   logic [sgm_pkg::LW_BITS-1:0]      cfg_width;
   logic [sgm_pkg::LC_BITS-1:0]      cfg_count;
   gradient_type                     expected_gradients[$];

   int          mismatch_count;
   int unsigned pixels_sent;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_requests;
   longint      cycle_count;

   sobel_gradient_magnitude_top dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_pixel         (req_pixel),
      .req_frame_start   (req_frame_start),
      .empty             (empty),
      .pop               (pop),
      .rsp_magnitude     (rsp_magnitude),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_of_frame (rsp_last_of_frame),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned eff_width();
      if (cfg_width < sgm_pkg::LINE_WIDTH_MIN) return sgm_pkg::LINE_WIDTH_MIN;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return int'(cfg_width);
   endfunction

   function automatic int unsigned eff_count();
      if (cfg_count < sgm_pkg::LINE_COUNT_MIN) return int'(sgm_pkg::LINE_COUNT_MIN);
      if (cfg_count > sgm_pkg::LINE_COUNT_MAX) return int'(sgm_pkg::LINE_COUNT_MAX);
      return int'(cfg_count);
   endfunction

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic void predict_gradient(logic [sgm_pkg::REQ_PIX_BITS-1:0] px, logic fs);
      int unsigned     w, h, col, row;
      int              above1, above2, gx, gy;
      longint unsigned sq;
      gradient_type    g;
      w = eff_width();
      h = eff_count();
      if (fs) begin
         pix_col = 0;
         pix_row = 0;
      end
      col = pix_col;
      row = pix_row;
      if (col >= MAX_WIDTH) col = 0;
      above1 = int'(prev_row_px[col]);
      above2 = int'(prev2_row_px[col]);
      prev2_row_px[col] = sgm_pkg::REQ_PIX_BITS'(above1);
      prev_row_px[col] = px;
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = above2;
      win[1][2] = above1;
      win[2][2] = int'(px);
      if (col >= 2 && row >= 2) begin
         gx = (win[0][2] + 2 * win[1][2] + win[2][2]) - (win[0][0] + 2 * win[1][0] + win[2][0]);
         gy = (win[0][0] + 2 * win[0][1] + win[0][2]) - (win[2][0] + 2 * win[2][1] + win[2][2]);
         sq = longint'(gx) * gx + longint'(gy) * gy;
         g.magnitude = sgm_pkg::MAG_BITS'(isqrt(sq));
         g.col = sgm_pkg::COL_OUT_BITS'(col - 2);
         g.row = sgm_pkg::ROW_BITS'(row - 2);
         g.last = (col + 1 >= w) && (row + 1 >= h);
         expected_gradients.push_back(g);
      end
      if (col + 1 >= w) begin
         pix_col = 0;
         pix_row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         pix_col = col + 1;
      end
   endfunction

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch: %s: expected %0d, got %0d", what, want, got);
   endfunction

   function automatic void check_gradient();
      gradient_type e;
      string        at;
      if (expected_gradients.size() == 0) begin
         note_mismatch("item with nothing pending, magnitude", 32'd0, 32'(rsp_magnitude));
         return;
      end
      e = expected_gradients.pop_front();
      at = $sformatf(" at col %0d row %0d", e.col, e.row);
      if (rsp_magnitude !== e.magnitude)
         note_mismatch({"magnitude", at}, 32'(e.magnitude), 32'(rsp_magnitude));
      if (rsp_out_col !== e.col) note_mismatch({"out_col", at}, 32'(e.col), 32'(rsp_out_col));
      if (rsp_out_row !== e.row) note_mismatch({"out_row", at}, 32'(e.row), 32'(rsp_out_row));
      if (rsp_last_of_frame !== e.last)
         note_mismatch({"last_of_frame", at}, 32'(e.last), 32'(rsp_last_of_frame));
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(80, 20);
      return $urandom_range(3, 1);
   endfunction

   function automatic logic [sgm_pkg::REQ_PIX_BITS-1:0] make_pixel(pix_style_type style,
                                                                   int unsigned base,
                                                                   int unsigned i);
      case (style)
         PIX_EXTREME: return ($urandom_range(1) != 0) ? PIX_ONES : '0;
         PIX_SMOOTH:  return sgm_pkg::REQ_PIX_BITS'(base + $urandom_range(15));
         PIX_RAMP:    return sgm_pkg::REQ_PIX_BITS'(base + i * 37);
         default:     return sgm_pkg::REQ_PIX_BITS'($urandom_range(PIX_MAX));
      endcase
   endfunction

   function automatic pix_style_type random_style();
      return pix_style_type'($urandom_range(3));
   endfunction

   // result side
   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) check_gradient();
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else begin
            hold_left = pick_gap(recv_idle_pct);
            pop <= (hold_left == 0);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   task automatic send_pixel(input logic [sgm_pkg::REQ_PIX_BITS-1:0] px, input logic fs);
      int gap;
      gap = pick_gap(send_idle_pct);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_pixel <= px;
      req_frame_start <= fs;
      do @(posedge clock); while (full);
      predict_gradient(px, fs);
      pixels_sent++;
   endtask

   task automatic send_run(input int unsigned n, input pix_style_type style, input bit start);
      int unsigned base;
      base = $urandom_range(PIX_MAX);
      for (int unsigned i = 0; i < n; i++)
         send_pixel(make_pixel(style, base, i), start && i == 0);
   endtask

   // border pixels make no item, so allow the pipeline to settle
   task automatic wait_idle();
      push <= 1'b0;
      while (expected_gradients.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      if (idx == sgm_pkg::REG_LINE_WIDTH) cfg_width = data[sgm_pkg::LW_BITS-1:0];
      else cfg_count = data[sgm_pkg::LC_BITS-1:0];
   endtask

   task automatic csr_check(input logic idx);
      logic [31:0] want;
      logic [31:0] got;
      want = (idx == sgm_pkg::REG_LINE_WIDTH) ? 32'(cfg_width) : 32'(cfg_count);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (got !== want)
         note_mismatch(idx == sgm_pkg::REG_LINE_WIDTH ? "line_width read" : "line_count read",
                       want, got);
   endtask

   task automatic test_register_access();
      csr_check(sgm_pkg::REG_LINE_WIDTH);
      csr_check(sgm_pkg::REG_LINE_COUNT);
      csr_write(sgm_pkg::REG_LINE_WIDTH, $urandom());
      csr_check(sgm_pkg::REG_LINE_WIDTH);
      csr_write(sgm_pkg::REG_LINE_COUNT, $urandom());
      csr_check(sgm_pkg::REG_LINE_COUNT);
      csr_write(sgm_pkg::REG_LINE_WIDTH, 32'hFFF);
      csr_check(sgm_pkg::REG_LINE_WIDTH);
      csr_write(sgm_pkg::REG_LINE_COUNT, 32'h1FFF);
      csr_check(sgm_pkg::REG_LINE_COUNT);
      csr_write(sgm_pkg::REG_LINE_WIDTH, MAX_WIDTH);
      csr_check(sgm_pkg::REG_LINE_WIDTH);
      csr_write(sgm_pkg::REG_LINE_COUNT, MAX_LINES);
      csr_check(sgm_pkg::REG_LINE_COUNT);
   endtask

   // 3x3 frames from out-of-range sizes: strong corner, its inverse by
   // frame wrap, then a restart after a stray pixel
   task automatic test_directed_frames();
      logic [sgm_pkg::REQ_PIX_BITS-1:0] corner [9];
      corner = '{PIX_ONES, PIX_ONES, PIX_ONES, '0, '0, PIX_ONES, '0, '0, '0};
      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(sgm_pkg::REG_LINE_WIDTH, 0);
      csr_write(sgm_pkg::REG_LINE_COUNT, 2);
      for (int i = 0; i < 9; i++) send_pixel(corner[i], i == 0);
      for (int i = 0; i < 9; i++) send_pixel(~corner[i], 1'b0);
      send_pixel(sgm_pkg::REQ_PIX_BITS'($urandom_range(PIX_MAX)), 1'b0);
      send_run(9, PIX_EXTREME, 1'b1);
      wait_idle();
   endtask

   task automatic test_full_queue_stall();
      csr_write(sgm_pkg::REG_LINE_WIDTH, 6);
      csr_write(sgm_pkg::REG_LINE_COUNT, 6);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      send_run(36, PIX_RANDOM, 1'b1);
      wait_idle();
   endtask

   task automatic test_random_frames();
      int unsigned target, old_w, new_w, frame_px, nframes, n;
      int          r;
      logic [31:0] w_reg, h_reg;
      bit          restart, fs;
      target = pixels_sent + RANDOM_ITEMS;
      while (pixels_sent < target) begin
         wait_idle();
         old_w = eff_width();
         r = $urandom_range(99);
         w_reg = (r < 10) ? $urandom_range(2) : (r < 90) ? $urandom_range(10, 3)
                                                          : $urandom_range(40, 11);
         h_reg = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(9, 3);
         csr_write(sgm_pkg::REG_LINE_WIDTH, w_reg);
         csr_write(sgm_pkg::REG_LINE_COUNT, h_reg);
         new_w = eff_width();
         // a wider line must start a fresh frame so no stale column is read
         restart = (new_w > old_w) || ($urandom_range(1) != 0);
         case ($urandom_range(2))
            0: send_idle_pct = 0;
            1: send_idle_pct = 10;
            default: send_idle_pct = 40;
         endcase
         case ($urandom_range(2))
            0: recv_idle_pct = 0;
            1: recv_idle_pct = 10;
            default: recv_idle_pct = 40;
         endcase
         frame_px = new_w * eff_count();
         nframes = $urandom_range(3, 1);
         for (int f = 0; f < nframes; f++) begin
            fs = (f == 0) ? restart : ($urandom_range(1) != 0);
            r = $urandom_range(99);
            if (r < 70) begin
               send_run(frame_px, random_style(), fs);
            end else if (r < 90) begin
               send_run($urandom_range(frame_px - 1, 1), random_style(), fs);
            end else begin
               n = $urandom_range(new_w, 1);
               for (int unsigned k = 0; k < n; k++)
                  send_pixel(sgm_pkg::REQ_PIX_BITS'($urandom_range(PIX_MAX)),
                             (fs && k == 0) || ($urandom_range(9) < 3));
            end
         end
      end
      wait_idle();
   endtask

   // widest line setting: the first stretch of a row yields no item
   task automatic test_widest_line();
      csr_write(sgm_pkg::REG_LINE_WIDTH, 32'hFFF);
      csr_write(sgm_pkg::REG_LINE_COUNT, 3);
      send_idle_pct = 5;
      recv_idle_pct = 5;
      send_run(WIDE_ITEMS, random_style(), 1'b1);
      wait_idle();
   endtask

   // tallest frame setting: a strip of rows, then more rows without a start flag
   task automatic test_tallest_frame();
      csr_write(sgm_pkg::REG_LINE_WIDTH, 1);
      csr_write(sgm_pkg::REG_LINE_COUNT, 32'h1FFF);
      send_idle_pct = 5;
      recv_idle_pct = 5;
      send_run(3 * TALL_ROWS, PIX_RANDOM, 1'b1);
      send_run(9, PIX_EXTREME, 1'b0);
      wait_idle();
   endtask

   initial begin
      reset <= 1'b1;
      push <= 1'b0;
      req_pixel <= '0;
      req_frame_start <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      mismatch_count = 0;
      pixels_sent = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests = 0;
      cfg_width = sgm_pkg::LW_RESET;
      cfg_count = sgm_pkg::LC_RESET;
      pix_col = 0;
      pix_row = 0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         prev_row_px[i] = '0;
         prev2_row_px[i] = '0;
      end
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) win[r][c] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_directed_frames();
      test_full_queue_stall();
      test_random_frames();
      test_widest_line();
      test_tallest_frame();
      wait_idle();
      if (mismatch_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/sgm_pkg.sv
hw/rtl/sgm_front.sv
hw/rtl/sgm_queue.sv
hw/rtl/sgm_back.sv
hw/rtl/sobel_gradient_magnitude_top.sv
tb/tb_top.sv
